// ----- hdl/rass_pkg.sv -----
`timescale 1ns / 1ps

package rass_pkg;

   localparam int RADAR_WORD_BITS_DEFAULT = 15;
   localparam int ALT_BITS_DEFAULT        = 16;

   localparam int RADAR_DATA_W = 15;
   localparam int ALT_VALUE_W  = 16;
   localparam int ALT_CODE_W   = 15;
   localparam int SCALER_W     = 7;
   localparam int STROBE_W     = 4;

   localparam logic OP_TICK      = 1'b0;
   localparam logic OP_ALT_WRITE = 1'b1;

   localparam logic [SCALER_W-1:0] SC_STROBE    = 7'o177;
   localparam logic [SCALER_W-1:0] SC_ALT_START = 7'o001;
   localparam logic [5:0]          SC_GTSET     = 6'o75;
   localparam logic [5:0]          SC_DISARM    = 6'o71;
   localparam logic [1:0]          SC_PULSE     = 2'b11;

   localparam logic [STROBE_W-1:0] STROBE_MAX    = 4'd15;
   localparam logic [STROBE_W-1:0] STROBE_SAMPLE = 4'd8;
   localparam logic [STROBE_W-1:0] STROBE_ARM    = 4'd9;

   localparam logic [ALT_CODE_W-1:0] ALT_CODE_ONE  = 15'o15;
   localparam logic [ALT_CODE_W-1:0] ALT_CODE_ZERO = 15'o16;

   localparam logic [1:0] PULSE_NONE  = 2'd0;
   localparam logic [1:0] PULSE_PLUS  = 2'd1;
   localparam logic [1:0] PULSE_MINUS = 2'd2;

   typedef struct packed {
      logic                    operation;
      logic [SCALER_W-1:0]     scaler;
      logic                    radar_activity;
      logic                    radar_unit;
      logic [1:0]              radar_item;
      logic [RADAR_DATA_W-1:0] radar_data;
      logic                    altitude_indicator;
      logic                    altitude_rate;
      logic [ALT_CODE_W-1:0]   alt_bit_code;
   } req_item_type;

   typedef struct packed {
      logic [1:0]             radar_count_pulse;
      logic                   alt_count_pulse;
      logic                   radar_sample;
      logic                   radar_unit_used;
      logic [1:0]             radar_item_used;
      logic                   radar_interrupt;
      logic                   clear_radar_activity;
      logic                   alt_valid;
      logic                   alt_is_rate;
      logic [ALT_VALUE_W-1:0] alt_value;
      logic                   clear_alt_indicator;
   } rsp_item_type;

endpackage

// ----- hdl/radar_altimeter_serial_sequencer_unit.sv -----
`timescale 1ns / 1ps
// The result item is registered in the cycle after the input item is accepted.
// One item is taken per cycle unless the output stalls; the single result register sets this rate.
// An item is taken whenever the result register is empty or being emptied.
// Reset (synchronous, active high) clears all sequencer state and the
// result valid flag.
module radar_altimeter_serial_sequencer_unit
   import rass_pkg::*;
#(
   parameter int RADAR_WORD_BITS = RADAR_WORD_BITS_DEFAULT,
   parameter int ALT_BITS        = ALT_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic                       activity_ff, activity_in;
   logic [STROBE_W-1:0]        count_ff, count_in;
   logic [RADAR_WORD_BITS-1:0] word_ff, word_in;
   logic                       radar_armed_ff, radar_armed_in;
   logic                       alt_armed_ff, alt_armed_in;
   logic [ALT_BITS-1:0]        alt_shift_ff, alt_shift_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_item_type               rsp_item_ff, rsp_item_in;

   logic                       req_take;
   logic [RADAR_WORD_BITS+RADAR_DATA_W-1:0] data_ext;
   logic [ALT_BITS+ALT_VALUE_W-1:0]         alt_ext;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign data_ext = {{RADAR_WORD_BITS{1'b0}}, req_item.radar_data};

   always_comb begin
      logic gtset;
      gtset          = (req_item.scaler[5:0] == SC_GTSET);
      activity_in    = activity_ff;
      count_in       = count_ff;
      word_in        = word_ff;
      radar_armed_in = radar_armed_ff;
      alt_armed_in   = alt_armed_ff;
      alt_shift_in   = alt_shift_ff;
      rsp_item_in    = '0;
      alt_ext        = {{ALT_VALUE_W{1'b0}}, alt_shift_ff};

      if (req_item.operation == OP_ALT_WRITE) begin
         if (req_item.alt_bit_code == ALT_CODE_ONE) begin
            alt_shift_in = {alt_shift_ff[ALT_BITS-2:0], 1'b1};
         end else if (req_item.alt_bit_code == ALT_CODE_ZERO) begin
            alt_shift_in = {alt_shift_ff[ALT_BITS-2:0], 1'b0};
         end
      end else begin
         if (req_item.scaler == SC_STROBE) begin
            activity_in = req_item.radar_activity;
            if (activity_in && count_in != STROBE_MAX) begin
               count_in = count_in + STROBE_W'(1);
            end
            if (count_in == STROBE_SAMPLE) begin
               word_in                     = data_ext[RADAR_WORD_BITS-1:0];
               rsp_item_in.radar_sample    = 1'b1;
               rsp_item_in.radar_unit_used = req_item.radar_unit;
               rsp_item_in.radar_item_used = req_item.radar_item;
            end
         end

         if (count_in == STROBE_ARM && gtset) begin
            radar_armed_in = 1'b1;
         end

         if (radar_armed_in) begin
            if (req_item.scaler[1:0] == SC_PULSE) begin
               rsp_item_in.radar_count_pulse =
                  word_in[RADAR_WORD_BITS-1] ? PULSE_PLUS : PULSE_MINUS;
               word_in = {word_in[RADAR_WORD_BITS-2:0], 1'b0};
            end
            if (req_item.scaler[5:0] == SC_DISARM) begin
               radar_armed_in                   = 1'b0;
               count_in                         = '0;
               rsp_item_in.radar_interrupt      = 1'b1;
               rsp_item_in.clear_radar_activity = 1'b1;
            end
         end

         if (req_item.scaler == SC_ALT_START && req_item.altitude_indicator) begin
            alt_armed_in = 1'b1;
            alt_shift_in = '0;
         end

         alt_ext = {{ALT_VALUE_W{1'b0}}, alt_shift_in};

         if (alt_armed_in) begin
            if (req_item.scaler[1:0] == SC_PULSE) begin
               rsp_item_in.alt_count_pulse = 1'b1;
            end else if (gtset) begin
               alt_armed_in                    = 1'b0;
               rsp_item_in.alt_valid           = 1'b1;
               rsp_item_in.alt_is_rate         = req_item.altitude_rate;
               rsp_item_in.alt_value           = alt_ext[ALT_VALUE_W-1:0];
               rsp_item_in.clear_alt_indicator = 1'b1;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         activity_ff    <= 1'b0;
         count_ff       <= '0;
         word_ff        <= '0;
         radar_armed_ff <= 1'b0;
         alt_armed_ff   <= 1'b0;
         alt_shift_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            activity_ff    <= activity_in;
            count_ff       <= count_in;
            word_ff        <= word_in;
            radar_armed_ff <= radar_armed_in;
            alt_armed_ff   <= alt_armed_in;
            alt_shift_ff   <= alt_shift_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

endmodule
